>>> rtl/flt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flt_pkg
// Shared sizes, request codes and sequencer states of the flow table.
// ----------------------------------------------------------------------------
package flt_pkg;

    // Pool geometry (BUCKETS is a power of two)
    localparam int ENTRIES = 64;
    localparam int BUCKETS = 64;
    localparam int IW      = $clog2(ENTRIES);
    localparam int PW      = $clog2(ENTRIES + 1);
    localparam int BKW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int MAXN    = (ENTRIES > BUCKETS) ? ENTRIES : BUCKETS;
    localparam int CW      = $clog2(MAXN);

    localparam int TIME_W  = 32;
    localparam int LIFE_W  = 31;
    localparam logic [LIFE_W-1:0] LIFE_RESET = LIFE_W'(3000);

    // Null link encoding
    localparam logic [PW-1:0] NIL = PW'(ENTRIES);

    // Beat widths
    localparam int S_DATA_W = 80;
    localparam int S_USER_W = 4;
    localparam int M_DATA_W = 24;
    localparam logic [6:0] CNT_MAX = 7'd127;

    typedef enum logic [3:0] {
        REQ_TICK      = 4'd0,
        REQ_ADD       = 4'd1,
        REQ_FIND      = 4'd2,
        REQ_FIND_TR   = 4'd3,
        REQ_REFRESH   = 4'd4,
        REQ_SET_STATE = 4'd5,
        REQ_SET_TRUST = 4'd6,
        REQ_DELETE    = 4'd7,
        REQ_DEL_ALL   = 4'd8,
        REQ_UNTRUST   = 4'd9
    } req_t;

    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE, ST_DISP,
        ST_SW_CHK, ST_SW_CMP, ST_EV, ST_AL, ST_AL1, ST_AP1, ST_AP2,
        ST_BK1, ST_BK2, ST_RF0, ST_RF1,
        ST_FND0, ST_FND1, ST_FND_CHK, ST_FND_CMP,
        ST_R0, ST_R1, ST_R2, ST_RW_RD, ST_RW_CK, ST_RET,
        ST_DA0, ST_DA1, ST_DA2, ST_DA3, ST_RESP
    } fsm_t;

endpackage

>>> rtl/flt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module flt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/flt_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flt_alu
// Shared 32-bit adder/subtractor for time stamps, wrap compares and hashing.
// ----------------------------------------------------------------------------
module flt_alu
    import flt_pkg::*;
(
    input  logic [TIME_W-1:0] a,
    input  logic [TIME_W-1:0] b,
    input  logic              sub,
    output logic [TIME_W-1:0] y
);

    // Add or subtract; the sign bit of a - b gives the wrap compare
    always_comb
    begin
        if (sub)
        begin
            y = a - b;
        end
        else
        begin
            y = a + b;
        end
    end

endmodule

>>> rtl/flow_table_lru_aging.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_table_lru_aging
// Hashed flow table with LRU eviction and timeout sweep.
// ----------------------------------------------------------------------------
// One request is taken at a time and answered by exactly one result beat;
// s_tready stays low while a request is in work. All per-entry fields and the
// bucket heads sit in single-port-read RAMs, so every link step takes an
// address step and then a registered-data step, and one shared 32-bit adder
// does all time arithmetic and hashing. Find walks its bucket chain; add may
// release entries by the sweep or eviction, each unlinked from its bucket
// chain; delete all / untrust all walk every bucket and each live entry.
// After reset a clearing pass builds the free list and empties the buckets
// before the first request is taken; life_time writes are taken at any time.
module flow_table_lru_aging
    import flt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // Configuration: life_time
    input  logic                cfg_wr_en,
    input  logic [LIFE_W-1:0]   cfg_wr_data,
    // Request stream
    input  logic                s_tvalid,
    output logic                s_tready,
    // src_addr[31:0], dst_addr[63:32], entry_index[69:64], value[77:70], pad
    input  logic [S_DATA_W-1:0] s_tdata,
    // req_type[3:0]
    input  logic [S_USER_W-1:0] s_tuser,
    // Result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    // hit[0], result_index[6:1], state_out[14:7], trusted_out[15],
    // evicted[16], expired_count[23:17]
    output logic [M_DATA_W-1:0] m_tdata
);

    // Control registers
    fsm_t                state_reg, state_next;
    logic [LIFE_W-1:0]   life_reg, life_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [TIME_W-1:0]   chk_reg, chk_next;
    logic [PW-1:0]       fhead_reg, fhead_next;
    logic [PW-1:0]       lhead_reg, lhead_next;
    logic [PW-1:0]       ltail_reg, ltail_next;
    logic [ENTRIES-1:0]  live_reg, live_next;
    logic [CW-1:0]       clr_reg, clr_next;
    logic                m_tvalid_reg, m_tvalid_next;

    // Working registers
    req_t                req_reg, req_next;
    logic [31:0]         src_reg, src_next;
    logic [31:0]         dst_reg, dst_next;
    logic [5:0]          idx_reg, idx_next;
    logic [7:0]          val_reg, val_next;
    logic [PW-1:0]       cur_reg, cur_next;
    logic [PW-1:0]       nx_reg, nx_next;
    logic [PW-1:0]       e_reg, e_next;
    logic [PW-1:0]       wk_reg, wk_next;
    logic [PW-1:0]       nb_reg, nb_next;
    logic [BKW-1:0]      bkt_reg, bkt_next;
    logic                evict_reg, evict_next;
    logic                hit_reg, hit_next;
    logic [5:0]          ridx_reg, ridx_next;
    logic [7:0]          rst_reg, rst_next;
    logic                rtr_reg, rtr_next;
    logic                rev_reg, rev_next;
    logic [6:0]          cnt_reg, cnt_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Shared adder
    logic [TIME_W-1:0]   alu_a, alu_b, alu_y;
    logic                alu_sub;
    logic                after_bit;
    logic [BKW-1:0]      bucket_y;

    // RAM ports
    logic [PW-1:0]       rd_ptr;
    logic [BKW-1:0]      bh_ra;
    logic                pair_we, st_we, tr_we, exp_we, bnx_we, lnx_we, lpv_we, fnx_we, bh_we;
    logic [PW-1:0]       pair_wa, st_wa, tr_wa, exp_wa, bnx_wa, lnx_wa, lpv_wa, fnx_wa;
    logic [BKW-1:0]      bh_wa;
    logic [63:0]         pair_wd, pair_q;
    logic [7:0]          st_wd, st_q;
    logic                tr_wd, tr_q;
    logic [TIME_W-1:0]   exp_wd, exp_q;
    logic [PW-1:0]       bnx_wd, bnx_q, lnx_wd, lnx_q, lpv_wd, lpv_q;
    logic [PW-1:0]       fnx_wd, fnx_q, bh_wd, bh_q;

    // Conditions
    logic                cur_nil, fh_nil, lh_nil, lt_nil;
    logic                idx_ok, ent_ok, fnd_ok, bkt_last;
    logic [PW-1:0]       idx_ptr;

    assign idx_ptr  = PW'(idx_reg);
    assign idx_ok   = (32'(idx_reg) < 32'(ENTRIES));
    assign ent_ok   = idx_ok && live_reg[IW'(idx_reg)];
    assign cur_nil  = (cur_reg == NIL);
    assign fh_nil   = (fhead_reg == NIL);
    assign lh_nil   = (lhead_reg == NIL);
    assign lt_nil   = (ltail_reg == NIL);
    assign bkt_last = (bkt_reg == BKW'(BUCKETS - 1));
    assign fnd_ok   = ((pair_q[31:0] == src_reg && pair_q[63:32] == dst_reg) ||
                       (pair_q[63:32] == src_reg && pair_q[31:0] == dst_reg)) &&
                      (req_reg == REQ_FIND || tr_q);
    assign after_bit = alu_y[TIME_W-1];
    assign bucket_y  = BKW'(alu_y & 32'(BUCKETS - 1));

    flt_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .y   (alu_y)
    );

    // Per-entry and per-bucket stores
    flt_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_pair (
        .clk(clk), .we(pair_we), .waddr(IW'(pair_wa)), .wdata(pair_wd),
        .raddr(IW'(rd_ptr)), .rdata(pair_q));
    flt_ram #(.WIDTH(8), .DEPTH(ENTRIES)) u_st (
        .clk(clk), .we(st_we), .waddr(IW'(st_wa)), .wdata(st_wd),
        .raddr(IW'(rd_ptr)), .rdata(st_q));
    flt_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_tr (
        .clk(clk), .we(tr_we), .waddr(IW'(tr_wa)), .wdata(tr_wd),
        .raddr(IW'(rd_ptr)), .rdata(tr_q));
    flt_ram #(.WIDTH(TIME_W), .DEPTH(ENTRIES)) u_exp (
        .clk(clk), .we(exp_we), .waddr(IW'(exp_wa)), .wdata(exp_wd),
        .raddr(IW'(rd_ptr)), .rdata(exp_q));
    flt_ram #(.WIDTH(PW), .DEPTH(ENTRIES)) u_bnx (
        .clk(clk), .we(bnx_we), .waddr(IW'(bnx_wa)), .wdata(bnx_wd),
        .raddr(IW'(rd_ptr)), .rdata(bnx_q));
    flt_ram #(.WIDTH(PW), .DEPTH(ENTRIES)) u_lnx (
        .clk(clk), .we(lnx_we), .waddr(IW'(lnx_wa)), .wdata(lnx_wd),
        .raddr(IW'(rd_ptr)), .rdata(lnx_q));
    flt_ram #(.WIDTH(PW), .DEPTH(ENTRIES)) u_lpv (
        .clk(clk), .we(lpv_we), .waddr(IW'(lpv_wa)), .wdata(lpv_wd),
        .raddr(IW'(rd_ptr)), .rdata(lpv_q));
    flt_ram #(.WIDTH(PW), .DEPTH(ENTRIES)) u_fnx (
        .clk(clk), .we(fnx_we), .waddr(IW'(fnx_wa)), .wdata(fnx_wd),
        .raddr(IW'(rd_ptr)), .rdata(fnx_q));
    flt_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_bh (
        .clk(clk), .we(bh_we), .waddr(bh_wa), .wdata(bh_wd),
        .raddr(bh_ra), .rdata(bh_q));

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:    if (clr_reg == CW'(MAXN - 1)) state_next = ST_IDLE;
            ST_IDLE:    if (s_tvalid) state_next = ST_DISP;
            ST_DISP:
            begin
                case (req_reg)
                    REQ_ADD:                state_next = after_bit ? ST_SW_CHK : ST_EV;
                    REQ_FIND, REQ_FIND_TR:  state_next = ST_FND0;
                    REQ_REFRESH:            state_next = ent_ok ? ST_RF0 : ST_RESP;
                    REQ_DELETE:             state_next = ent_ok ? ST_R0 : ST_RESP;
                    REQ_DEL_ALL, REQ_UNTRUST: state_next = ST_DA0;
                    default:                state_next = ST_RESP;
                endcase
            end
            ST_SW_CHK:  state_next = cur_nil ? ST_EV : ST_SW_CMP;
            ST_SW_CMP:  state_next = after_bit ? ST_R0 : ST_EV;
            ST_EV:      state_next = (fh_nil && !lh_nil) ? ST_R0 : ST_AL;
            ST_AL:      state_next = fh_nil ? ST_RESP : ST_AL1;
            ST_AL1:     state_next = ST_AP2;
            ST_AP1:     state_next = ST_AP2;
            ST_AP2:     state_next = (req_reg == REQ_ADD) ? ST_BK1 : ST_RESP;
            ST_BK1:     state_next = ST_BK2;
            ST_BK2:     state_next = ST_RESP;
            ST_RF0:     state_next = ST_RF1;
            ST_RF1:     state_next = ST_AP1;
            ST_FND0:    state_next = ST_FND1;
            ST_FND1:    state_next = ST_FND_CHK;
            ST_FND_CHK: state_next = cur_nil ? ST_RESP : ST_FND_CMP;
            ST_FND_CMP: state_next = fnd_ok ? ST_RESP : ST_FND_CHK;
            ST_R0:      state_next = ST_R1;
            ST_R1:      state_next = ST_R2;
            ST_R2:      state_next = (bh_q == e_reg) ? ST_RET : ST_RW_RD;
            ST_RW_RD:   state_next = ST_RW_CK;
            ST_RW_CK:   state_next = (bnx_q == e_reg || bnx_q == NIL) ? ST_RET : ST_RW_RD;
            ST_RET:
            begin
                if (req_reg == REQ_ADD)
                begin
                    state_next = evict_reg ? ST_AL : ST_SW_CHK;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_DA0:     state_next = ST_DA1;
            ST_DA1:     state_next = ST_DA2;
            ST_DA2:
            begin
                if (!cur_nil)
                begin
                    state_next = ST_DA3;
                end
                else
                begin
                    state_next = bkt_last ? ST_RESP : ST_DA0;
                end
            end
            ST_DA3:     state_next = ST_DA2;
            ST_RESP:    if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:    state_next = ST_INIT;
        endcase
    end

    // Datapath and RAM controls
    always_comb
    begin
        life_next  = cfg_wr_en ? cfg_wr_data : life_reg;
        now_next   = now_reg;
        chk_next   = chk_reg;
        fhead_next = fhead_reg;
        lhead_next = lhead_reg;
        ltail_next = ltail_reg;
        live_next  = live_reg;
        clr_next   = clr_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        req_next   = req_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        cur_next   = cur_reg;
        nx_next    = nx_reg;
        e_next     = e_reg;
        wk_next    = wk_reg;
        nb_next    = nb_reg;
        bkt_next   = bkt_reg;
        evict_next = evict_reg;
        hit_next   = hit_reg;
        ridx_next  = ridx_reg;
        rst_next   = rst_reg;
        rtr_next   = rtr_reg;
        rev_next   = rev_reg;
        cnt_next   = cnt_reg;

        alu_a   = now_reg;
        alu_b   = {1'b0, life_reg};
        alu_sub = 1'b0;
        rd_ptr  = cur_reg;
        bh_ra   = bkt_reg;

        pair_we = 1'b0; pair_wa = e_reg;   pair_wd = {dst_reg, src_reg};
        st_we   = 1'b0; st_wa   = idx_ptr; st_wd   = val_reg;
        tr_we   = 1'b0; tr_wa   = idx_ptr; tr_wd   = (val_reg != 8'd0);
        exp_we  = 1'b0; exp_wa  = e_reg;   exp_wd  = alu_y;
        bnx_we  = 1'b0; bnx_wa  = e_reg;   bnx_wd  = bh_q;
        lnx_we  = 1'b0; lnx_wa  = e_reg;   lnx_wd  = NIL;
        lpv_we  = 1'b0; lpv_wa  = e_reg;   lpv_wd  = ltail_reg;
        fnx_we  = 1'b0; fnx_wa  = e_reg;   fnx_wd  = fhead_reg;
        bh_we   = 1'b0; bh_wa   = bkt_reg; bh_wd   = NIL;

        case (state_reg)
            // Build the free chain and empty the buckets
            ST_INIT:
            begin
                clr_next = CW'(32'(clr_reg) + 32'd1);
                if (32'(clr_reg) < 32'(ENTRIES))
                begin
                    fnx_we = 1'b1;
                    fnx_wa = PW'(clr_reg);
                    fnx_wd = PW'(32'(clr_reg) + 32'd1);
                end
                if (32'(clr_reg) < 32'(BUCKETS))
                begin
                    bh_we = 1'b1;
                    bh_wa = BKW'(clr_reg);
                end
            end
            // Latch the request beat and clear the result
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next   = req_t'(s_tuser);
                    src_next   = s_tdata[31:0];
                    dst_next   = s_tdata[63:32];
                    idx_next   = s_tdata[69:64];
                    val_next   = s_tdata[77:70];
                    evict_next = 1'b0;
                    hit_next   = 1'b0;
                    ridx_next  = 6'd0;
                    rst_next   = 8'd0;
                    rtr_next   = 1'b0;
                    rev_next   = 1'b0;
                    cnt_next   = 7'd0;
                end
            end
            ST_DISP:
            begin
                case (req_reg)
                    REQ_TICK:
                    begin
                        alu_b    = 32'd1;
                        now_next = alu_y;
                    end
                    REQ_ADD:
                    begin
                        alu_a   = chk_reg;
                        alu_b   = now_reg;
                        alu_sub = 1'b1;
                        cur_next = lhead_reg;
                    end
                    REQ_SET_STATE: st_we = idx_ok;
                    REQ_SET_TRUST: tr_we = idx_ok;
                    REQ_REFRESH, REQ_DELETE: e_next = idx_ptr;
                    REQ_DEL_ALL, REQ_UNTRUST: bkt_next = BKW'(0);
                    default: ;
                endcase
            end
            // Sweep expired entries from the LRU head
            ST_SW_CHK:
            begin
                if (cur_nil)
                begin
                    chk_next = alu_y;
                end
            end
            ST_SW_CMP:
            begin
                alu_a   = exp_q;
                alu_b   = now_reg;
                alu_sub = 1'b1;
                if (after_bit)
                begin
                    nx_next = lnx_q;
                    e_next  = cur_reg;
                    if (cnt_reg != CNT_MAX)
                    begin
                        cnt_next = cnt_reg + 7'd1;
                    end
                end
                else
                begin
                    chk_next = exp_q;
                end
            end
            // Evict the oldest entry when the pool is full
            ST_EV:
            begin
                if (fh_nil && !lh_nil)
                begin
                    e_next     = lhead_reg;
                    evict_next = 1'b1;
                    rev_next   = 1'b1;
                end
            end
            ST_AL:
            begin
                rd_ptr = fhead_reg;
                e_next = fhead_reg;
            end
            // Pop the free list and fill the entry on allocation; start the LRU append
            ST_AL1, ST_AP1:
            begin
                exp_we = 1'b1;
                lnx_we = 1'b1;
                lpv_we = 1'b1;
                if (state_reg == ST_AL1)
                begin
                    fhead_next = fnx_q;
                    live_next[IW'(e_reg)] = 1'b1;
                    pair_we = 1'b1;
                    st_we   = 1'b1;
                    st_wa   = e_reg;
                    tr_we   = 1'b1;
                    tr_wa   = e_reg;
                    tr_wd   = 1'b0;
                    hit_next  = 1'b1;
                    ridx_next = 6'(e_reg);
                    rst_next  = val_reg;
                end
            end
            // Hook the entry behind the old tail
            ST_AP2:
            begin
                if (lt_nil)
                begin
                    lhead_next = e_reg;
                end
                else
                begin
                    lnx_we = 1'b1;
                    lnx_wa = ltail_reg;
                    lnx_wd = e_reg;
                end
                ltail_next = e_reg;
            end
            // Push the new entry on its bucket
            ST_BK1:
            begin
                alu_a    = src_reg;
                alu_b    = dst_reg;
                bh_ra    = bucket_y;
                bkt_next = bucket_y;
            end
            ST_BK2:
            begin
                bnx_we = 1'b1;
                bh_we  = 1'b1;
                bh_wd  = e_reg;
            end
            ST_RF0, ST_R0:
            begin
                rd_ptr = e_reg;
            end
            // Unlink from the LRU; a release also frees the entry
            ST_RF1, ST_R1:
            begin
                if (lpv_q == NIL)
                begin
                    lhead_next = lnx_q;
                end
                else
                begin
                    lnx_we = 1'b1;
                    lnx_wa = lpv_q;
                    lnx_wd = lnx_q;
                end
                if (lnx_q == NIL)
                begin
                    ltail_next = lpv_q;
                end
                else
                begin
                    lpv_we = 1'b1;
                    lpv_wa = lnx_q;
                    lpv_wd = lpv_q;
                end
                if (state_reg == ST_R1)
                begin
                    alu_a      = pair_q[31:0];
                    alu_b      = pair_q[63:32];
                    bh_ra      = bucket_y;
                    bkt_next   = bucket_y;
                    nb_next    = bnx_q;
                    fnx_we     = 1'b1;
                    fhead_next = e_reg;
                    live_next[IW'(e_reg)] = 1'b0;
                    exp_we     = 1'b1;
                    exp_wd     = '0;
                end
            end
            // Unlink from the bucket chain
            ST_R2:
            begin
                if (bh_q == e_reg)
                begin
                    bh_we = 1'b1;
                    bh_wd = nb_reg;
                end
                else
                begin
                    wk_next = bh_q;
                end
            end
            ST_RW_RD:
            begin
                rd_ptr = wk_reg;
            end
            ST_RW_CK:
            begin
                if (bnx_q == e_reg)
                begin
                    bnx_we = 1'b1;
                    bnx_wa = wk_reg;
                    bnx_wd = nb_reg;
                end
                else
                begin
                    wk_next = bnx_q;
                end
            end
            ST_RET:
            begin
                if (req_reg == REQ_ADD && !evict_reg)
                begin
                    cur_next = nx_reg;
                end
            end
            // Walk the bucket chain for a match
            ST_FND0:
            begin
                alu_a = src_reg;
                alu_b = dst_reg;
                bh_ra = bucket_y;
            end
            ST_FND1, ST_DA1:
            begin
                cur_next = bh_q;
            end
            ST_FND_CMP:
            begin
                if (fnd_ok)
                begin
                    hit_next  = 1'b1;
                    ridx_next = 6'(cur_reg);
                    rst_next  = st_q;
                    rtr_next  = tr_q;
                end
                else
                begin
                    cur_next = bnx_q;
                end
            end
            // Bucket sweep for delete all and untrust all
            ST_DA2:
            begin
                if (cur_nil)
                begin
                    bkt_next = BKW'(32'(bkt_reg) + 32'd1);
                    if (req_reg == REQ_DEL_ALL)
                    begin
                        bh_we = 1'b1;
                        if (bkt_last)
                        begin
                            lhead_next = NIL;
                            ltail_next = NIL;
                        end
                    end
                end
            end
            ST_DA3:
            begin
                cur_next = bnx_q;
                if (req_reg == REQ_DEL_ALL)
                begin
                    fnx_we     = 1'b1;
                    fnx_wa     = cur_reg;
                    fhead_next = cur_reg;
                    live_next[IW'(cur_reg)] = 1'b0;
                    exp_we     = 1'b1;
                    exp_wa     = cur_reg;
                    exp_wd     = '0;
                end
                else
                begin
                    tr_we = 1'b1;
                    tr_wa = cur_reg;
                    tr_wd = 1'b0;
                end
            end
            // Hand the result to the output register
            ST_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {cnt_reg, rev_reg, rtr_reg, rst_reg, ridx_reg, hit_reg};
                end
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            life_reg     <= LIFE_RESET;
            now_reg      <= '0;
            chk_reg      <= TIME_W'(LIFE_RESET);
            fhead_reg    <= '0;
            lhead_reg    <= NIL;
            ltail_reg    <= NIL;
            live_reg     <= '0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            life_reg     <= life_next;
            now_reg      <= now_next;
            chk_reg      <= chk_next;
            fhead_reg    <= fhead_next;
            lhead_reg    <= lhead_next;
            ltail_reg    <= ltail_next;
            live_reg     <= live_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        idx_reg     <= idx_next;
        val_reg     <= val_next;
        cur_reg     <= cur_next;
        nx_reg      <= nx_next;
        e_reg       <= e_next;
        wk_reg      <= wk_next;
        nb_reg      <= nb_next;
        bkt_reg     <= bkt_next;
        evict_reg   <= evict_next;
        hit_reg     <= hit_next;
        ridx_reg    <= ridx_next;
        rst_reg     <= rst_next;
        rtr_reg     <= rtr_next;
        rev_reg     <= rev_next;
        cnt_reg     <= cnt_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef NO_ASSERTIONS
    // The free head never points at a live entry
    a_free_head_dead: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && fhead_reg != NIL) |-> !live_reg[IW'(fhead_reg)])
        else $error("free head is live");

    // LRU head and tail are empty together between requests
    a_lru_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> ((lhead_reg == NIL) == (ltail_reg == NIL)))
        else $error("lru ends disagree");

    // A result beat is only launched from the response state
    a_resp_src: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid_reg && m_tvalid_next) |-> state_reg == ST_RESP)
        else $error("result beat outside response");

    // An accepted request starts with a clear sweep count
    a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> cnt_reg == 7'd0)
        else $error("sweep count not cleared");
`endif

endmodule
